>>> src/assert_macros.svh
// assertion helpers for the top-level rtl file
// no dependencies; included inside module bodies after the package import
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// plain implication check on a clock, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

>>> src/utf8d_pkg.sv
// shared types and constants of the utf-8 stream decoder
// no dependencies; imported by every module of the block
package utf8d_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CP_W        = 32;
   localparam int unsigned REM_W       = 3;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [CP_W-1:0] MAX_CP_RESET = 32'h0000_FFFF;
   localparam logic [CP_W-1:0] QMARK_CP     = 32'h0000_003F;
   localparam logic [BYTE_W-1:0] BYTE_ALL_ONES = 8'hFF;
   localparam logic [1:0]      CONT_TAG     = 2'b10;

   // one result item
   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            replaced;
      logic            last_of_run;
   } rsp_item_type;

   // queue status seen by the top level
   typedef struct packed {
      logic [3:0] count;
      logic       room_two;
   } queue_status_type;

endpackage

>>> src/utf8d_decode.sv
// combinational decode of one byte against the current sequence state
// depends on utf8d_pkg
module utf8d_decode (
   input  logic [utf8d_pkg::BYTE_W-1:0] in_byte,
   input  logic [utf8d_pkg::CP_W-1:0]   acc,
   input  logic [utf8d_pkg::REM_W-1:0]  rem,
   input  logic [utf8d_pkg::CP_W-1:0]   max_cp,
   output logic [utf8d_pkg::CP_W-1:0]   acc_next,
   output logic [utf8d_pkg::REM_W-1:0]  rem_next,
   output logic [1:0]                   num_results,
   output utf8d_pkg::rsp_item_type      result0,
   output utf8d_pkg::rsp_item_type      result1
);
   import utf8d_pkg::*;

   logic [REM_W-1:0]  lead_len;
   logic [BYTE_W-1:0] lead_mask;
   logic [CP_W-1:0]   lead_acc;
   logic [CP_W-1:0]   shifted_acc;
   logic [REM_W-1:0]  rem_dec;

   // range check against the maximum register
   function automatic rsp_item_type checked(input logic [CP_W-1:0] v,
                                            input logic [CP_W-1:0] limit,
                                            input logic last);
      rsp_item_type r;
      r.last_of_run = last;
      if (v > limit) begin
         r.code_point = QMARK_CP;
         r.replaced   = 1'b1;
      end else begin
         r.code_point = v;
         r.replaced   = 1'b0;
      end
      return r;
   endfunction

   // leading-ones count and payload mask of a lead byte
   always_comb begin
      unique casez (in_byte)
         8'b10??_????: begin lead_len = 3'd1; lead_mask = 8'h3F; end
         8'b110?_????: begin lead_len = 3'd2; lead_mask = 8'h1F; end
         8'b1110_????: begin lead_len = 3'd3; lead_mask = 8'h0F; end
         8'b1111_0???: begin lead_len = 3'd4; lead_mask = 8'h07; end
         8'b1111_10??: begin lead_len = 3'd5; lead_mask = 8'h03; end
         8'b1111_110?: begin lead_len = 3'd6; lead_mask = 8'h01; end
         8'b1111_1110: begin lead_len = 3'd7; lead_mask = 8'h00; end
         default:      begin lead_len = 3'd0; lead_mask = 8'h00; end
      endcase
   end

   assign lead_acc = {{(CP_W-BYTE_W){1'b0}}, in_byte & lead_mask};
   assign rem_dec  = rem - 3'd1;

   // continuation adds six bits, any other byte adds all eight
   assign shifted_acc = (in_byte[7:6] == CONT_TAG) ? {acc[CP_W-7:0], in_byte[5:0]}
                                                   : {acc[CP_W-9:0], in_byte};

   // next state and results
   always_comb begin
      acc_next    = acc;
      rem_next    = rem;
      num_results = 2'd0;
      result0     = '0;
      result1     = '0;
      if (rem == '0) begin
         if (!in_byte[7]) begin
            // ascii passes through unchecked
            num_results          = 2'd1;
            result0.code_point   = {{(CP_W-BYTE_W){1'b0}}, in_byte};
            result0.last_of_run  = 1'b1;
         end else if (in_byte == BYTE_ALL_ONES) begin
            num_results          = 2'd1;
            result0.code_point   = QMARK_CP;
            result0.replaced     = 1'b1;
            result0.last_of_run  = 1'b1;
         end else if (lead_len == 3'd1) begin
            // single-byte sequence completes at once
            num_results = 2'd1;
            result0     = checked(lead_acc, max_cp, 1'b1);
            acc_next    = '0;
         end else begin
            acc_next = lead_acc;
            rem_next = lead_len - 3'd1;
         end
      end else if (in_byte == '0) begin
         // zero byte ends the sequence early
         num_results          = 2'd2;
         result0              = checked(acc, max_cp, 1'b0);
         result1.last_of_run  = 1'b1;
         acc_next             = '0;
         rem_next             = '0;
      end else begin
         rem_next = rem_dec;
         if (rem_dec == '0) begin
            num_results = 2'd1;
            result0     = checked(shifted_acc, max_cp, 1'b1);
            acc_next    = '0;
         end else begin
            acc_next = shifted_acc;
         end
      end
   end

endmodule

>>> src/utf8d_rsp_queue.sv
// small result queue: takes up to two items per cycle, gives one
// depends on utf8d_pkg
module utf8d_rsp_queue #(
   parameter int unsigned DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   push_num,
   input  utf8d_pkg::rsp_item_type      push0,
   input  utf8d_pkg::rsp_item_type      push1,
   output utf8d_pkg::rsp_item_type      head,
   output logic                         head_valid,
   input  logic                         pop,
   output utf8d_pkg::queue_status_type  status
);
   import utf8d_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   rsp_item_type     entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [PTR_W-1:0] wr_ptr_p1, wr_ptr_p2;
   logic             do_pop;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
   endfunction

   assign wr_ptr_p1 = wrap_inc(wr_ptr_ff);
   assign wr_ptr_p2 = wrap_inc(wr_ptr_p1);
   assign do_pop    = pop && (count_ff != '0);

   // pointer and fill count update
   always_comb begin
      rd_ptr_in = do_pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      case (push_num)
         2'd1:    wr_ptr_in = wr_ptr_p1;
         2'd2:    wr_ptr_in = wr_ptr_p2;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CNT_W'(push_num) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_num != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push0;
      end
      if (push_num == 2'd2) begin
         entries_ff[wr_ptr_p1] <= push1;
      end
   end

   assign head            = entries_ff[rd_ptr_ff];
   assign head_valid      = (count_ff != '0);
   assign status.count    = 4'(count_ff);
   assign status.room_two = (32'(count_ff) + 32'd2 <= DEPTH);

endmodule

>>> src/utf8_stream_decoder.sv
// Byte-stream UTF-8 decoder: one byte per req item, code points out on rsp.
// A byte is taken every cycle while the result queue has room for two items;
// it is held in the input register, is decoded there in a single pass,
// and its results (none, one, or two for a zero byte that cuts a sequence
// short) are pushed into the result queue that drives rsp. Sustained rate
// is one byte per cycle; a stalled rsp side fills the QUEUE_DEPTH-entry
// result queue until it lacks room for two items, which holds req_tready low.
// Top level; depends on utf8d_pkg, utf8d_decode, utf8d_rsp_queue.
module utf8_stream_decoder #(
   parameter int unsigned QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   // configuration: max_code_point
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [utf8d_pkg::CP_W-1:0]  csr_data,
   // input items
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] in_byte
   // result items
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,   // [31:0] code_point
   output logic                        rsp_tuser,   // [0] replaced
   output logic                        rsp_tlast    // last_of_run
);
   import utf8d_pkg::*;
   `include "assert_macros.svh"

   logic [CP_W-1:0]   max_cp_ff;
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [CP_W-1:0]   acc_ff, acc_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [1:0]        num_results;
   rsp_item_type      result0, result1, head;
   queue_status_type  q_status;
   logic              consume;
   logic              req_accept;

   assign csr_ready  = 1'b1;
   assign consume    = in_valid_ff && q_status.room_two;
   assign req_tready = !in_valid_ff || consume;
   assign req_accept = req_tvalid && req_tready;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_cp_ff <= MAX_CP_RESET;
      end else if (csr_valid) begin
         max_cp_ff <= csr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (consume) begin
         in_valid_ff <= 1'b0;
      end
      if (req_accept) begin
         in_byte_ff <= req_tdata;
      end
   end

   utf8d_decode u_decode (
      .in_byte     (in_byte_ff),
      .acc         (acc_ff),
      .rem         (rem_ff),
      .max_cp      (max_cp_ff),
      .acc_next    (acc_in),
      .rem_next    (rem_in),
      .num_results (num_results),
      .result0     (result0),
      .result1     (result1)
   );

   // sequence state advances when the held item is decoded
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         rem_ff <= '0;
      end else if (consume) begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
      end
   end

   utf8d_rsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_num   (consume ? num_results : 2'd0),
      .push0      (result0),
      .push1      (result1),
      .head       (head),
      .head_valid (rsp_tvalid),
      .pop        (rsp_tready),
      .status     (q_status)
   );

   assign rsp_tdata = head.code_point;
   assign rsp_tuser = head.replaced;
   assign rsp_tlast = head.last_of_run;

   // checks
   `ASSERT_CLK(a_queue_bound, clock, reset, (32'(q_status.count) <= QUEUE_DEPTH), "result queue overfilled")
   `ASSERT_IMPLIES(a_zero_ends_seq, clock, reset, consume && (rem_ff != '0) && (in_byte_ff == '0), ##1 (rem_ff == '0) && (acc_ff == '0), "zero byte did not end the sequence")
   `ASSERT_IMPLIES(a_valid_tracks_queue, clock, reset, consume && (num_results != 2'd0), ##1 rsp_tvalid, "decoded item missing from rsp")

endmodule

>>> bench/utf8d_check_pkg.sv
// expected-result tracker for the utf-8 stream decoder bench
// depends on utf8d_pkg for widths, constants and the result item type
package utf8d_check_pkg;

   import utf8d_pkg::*;

   class utf8_decode_tracker;
      logic [CP_W-1:0] max_cp;
      logic [CP_W-1:0] accum;
      int unsigned     remaining;
      rsp_item_type    pending_chars[$];
      int unsigned     mismatches;

      function new();
         max_cp     = MAX_CP_RESET;
         accum      = '0;
         remaining  = 0;
         mismatches = 0;
      endfunction

      function void set_max(logic [CP_W-1:0] value);
         max_cp = value;
      endfunction

      function bit mid_sequence();
         return remaining != 0;
      endfunction

      function int unsigned outstanding();
         return pending_chars.size();
      endfunction

      function void push_plain(logic [CP_W-1:0] value, logic rep, logic last);
         rsp_item_type item;
         item.code_point  = value;
         item.replaced    = rep;
         item.last_of_run = last;
         pending_chars.push_back(item);
      endfunction

      // completed character, range checked against the current maximum
      function void push_checked(logic [CP_W-1:0] value, logic last);
         if (value > max_cp) begin
            push_plain(QMARK_CP, 1'b1, last);
         end else begin
            push_plain(value, 1'b0, last);
         end
      endfunction

      // one accepted byte: update decode state, queue the characters it yields
      function void note_byte(logic [BYTE_W-1:0] b);
         int unsigned ones;
         if (remaining == 0) begin
            if (!b[7]) begin
               push_plain(CP_W'(b), 1'b0, 1'b1);
            end else if (b == BYTE_ALL_ONES) begin
               push_plain(QMARK_CP, 1'b1, 1'b1);
            end else begin
               // count leading ones, payload sits below the first zero
               ones = 0;
               while (b[7 - ones]) ones++;
               accum     = CP_W'(b) & ((32'd1 << (7 - ones)) - 32'd1);
               remaining = ones - 1;
               if (remaining == 0) begin
                  push_checked(accum, 1'b1);
                  accum = '0;
               end
            end
         end else if (b == 8'h00) begin
            // zero cuts the sequence short: pending char, then the zero
            push_checked(accum, 1'b0);
            push_plain('0, 1'b0, 1'b1);
            accum     = '0;
            remaining = 0;
         end else begin
            if (b[7:6] == CONT_TAG) begin
               accum = {accum[CP_W-7:0], b[5:0]};
            end else begin
               accum = {accum[CP_W-9:0], b};
            end
            remaining--;
            if (remaining == 0) begin
               push_checked(accum, 1'b1);
               accum = '0;
            end
         end
      endfunction

      // compare one delivered character with the oldest one expected
      function void check_result(logic [CP_W-1:0] cp, logic rep, logic last);
         rsp_item_type want;
         if (pending_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected character: cp=%h replaced=%b last=%b", cp, rep, last);
            return;
         end
         want = pending_chars.pop_front();
         if (want.code_point !== cp || want.replaced !== rep || want.last_of_run !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected cp=%h replaced=%b last=%b, got cp=%h replaced=%b last=%b",
                        want.code_point, want.replaced, want.last_of_run, cp, rep, last);
         end
      endfunction
   endclass

endpackage

>>> bench/tb_utf8_stream_decoder.sv
// top-level bench for utf8_stream_decoder: directed and random byte streams
// under several max_code_point settings; depends on utf8d_pkg, utf8d_check_pkg, utf8_stream_decoder
module tb_utf8_stream_decoder;

   import utf8d_pkg::*;
   import utf8d_check_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PHASE_ITEMS  = 110;
   localparam int unsigned NUM_PHASES   = 8;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CP_W-1:0]  csr_data = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata = '0;   // [7:0] in_byte
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [31:0]      rsp_tdata;        // [31:0] code_point
   logic             rsp_tuser;        // [0] replaced
   logic             rsp_tlast;

   utf8_decode_tracker tracker = new();
   bit                 idling_on = 1'b1;

   utf8_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL utf8_stream_decoder");
      $finish;
   end

   // rsp back-pressure in random bursts
   initial begin
      int unsigned span;
      forever begin
         if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            span = $urandom_range(1, 15);
         end else begin
            rsp_tready <= 1'b1;
            span = $urandom_range(1, 20);
         end
         repeat (span) @(posedge clock);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // one byte on req, with an optional idle burst first; tvalid stays high after
   task automatic send_byte(logic [7:0] b);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      tracker.note_byte(b);
   endtask

   task automatic write_max(logic [CP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.set_max(value);
   endtask

   // close any open sequence with a zero, then wait for the block to drain
   task automatic finish_phase();
      if (tracker.mid_sequence())
         send_byte(8'h00);
      req_tvalid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly well-formed sequences with random payload, some cut short or noisy
   task automatic run_random_phase(int unsigned count);
      int unsigned sent;
      int unsigned pick;
      int unsigned len;
      int unsigned followers;
      logic [7:0]  lead;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : $urandom_range(2, 4);
            if (len == 7)
               lead = 8'hFE;
            else
               lead = (8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1)));
            send_byte(lead);
            sent++;
            followers = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len - 1;
            repeat (followers) begin
               if ($urandom_range(0, 9) == 0)
                  send_byte(8'($urandom));
               else
                  send_byte({CONT_TAG, 6'($urandom)});
               sent++;
            end
         end else if (pick < 80) begin
            send_byte({1'b0, 7'($urandom)});
            sent++;
         end else if (pick < 85) begin
            send_byte(BYTE_ALL_ONES);
            sent++;
         end else if (pick < 90) begin
            send_byte(8'h00);
            sent++;
         end else begin
            send_byte(8'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      // ascii ends, 0xff, one-byte leads, 2/3/4-byte chars, 0xfe lead,
      // non-continuation byte mid-sequence, zero cutting a sequence
      logic [7:0]      opening [24] = '{
         8'h00, 8'h7F, 8'hFF, 8'h80, 8'hBF,
         8'hC3, 8'hA9,
         8'hE2, 8'h82, 8'hAC,
         8'hF0, 8'h9F, 8'h98, 8'h80,
         8'hFE, 8'hBF, 8'h80, 8'hBF, 8'h80, 8'hBF, 8'h80,
         8'hE2, 8'h41, 8'h00
      };
      logic [CP_W-1:0] limits [NUM_PHASES] = '{
         32'h0000_0000, 32'hFFFF_FFFF, 32'h0010_FFFF, 32'h0000_007F,
         32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_FFFF
      };
      logic [CP_W-1:0] value;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i])
         send_byte(opening[i]);
      finish_phase();

      for (int p = 0; p < NUM_PHASES; p++) begin
         value = limits[p];
         if (p == 4)
            value = $urandom;
         if (p == 5)
            value = $urandom_range(0, 4095);
         if (p == NUM_PHASES - 1)
            idling_on = 1'b0;
         write_max(value);
         run_random_phase(PHASE_ITEMS);
         finish_phase();
      end

      if (tracker.mismatches == 0 && tracker.outstanding() == 0)
         $display("PASS utf8_stream_decoder");
      else
         $display("FAIL utf8_stream_decoder");
      $finish;
   end

endmodule

>>> utf8_stream_decoder.f
+incdir+src
src/utf8d_pkg.sv
src/utf8d_decode.sv
src/utf8d_rsp_queue.sv
src/utf8_stream_decoder.sv
bench/utf8d_check_pkg.sv
bench/tb_utf8_stream_decoder.sv
